// ----- rtl/polygon_radial_distance_sampler_defines.svh -----
// ----------------------------------------------------------------------------
// Polygon radial distance sampler: assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POLYGON_RADIAL_DISTANCE_SAMPLER_DEFINES_SVH
`define POLYGON_RADIAL_DISTANCE_SAMPLER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define PRDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define PRDS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/prds_pkg.sv -----
// ----------------------------------------------------------------------------
// prds_pkg
// Widths, constants and types shared by the radial distance sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package prds_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned XW       = 35;  // CORDIC x/y
  localparam int unsigned ZW       = 34;  // CORDIC angle accumulator
  localparam int unsigned TW       = 33;  // angle in turns, 0 .. 2^32
  localparam int unsigned NS_W     = 7;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned DIV_WN   = 62;
  localparam int unsigned DIV_WD   = 50;
  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned STEP_W   = 5;

  localparam logic [DIST_W-1:0]   DIST_INIT = 16'd7288;  // 7288, in whole coordinate units
  localparam logic signed [XW-1:0] INV_GAIN = 35'sd652032874;

  localparam logic [TW-1:0] TURN          = 33'h1_0000_0000;
  localparam logic [TW-1:0] HALF_TURN     = 33'h0_8000_0000;
  localparam logic [TW-1:0] QUARTER_TURN  = 33'h0_4000_0000;
  localparam logic [TW-1:0] THREE_QUARTER = 33'h0_C000_0000;

  // atan(2^-i) in turns scaled by 2^32
  localparam logic [29:0] ATAN_TURN [ATAN_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_req_t;

endpackage

`default_nettype wire

// ----- rtl/polygon_radial_distance_sampler.sv -----
// ----------------------------------------------------------------------------
// polygon_radial_distance_sampler
// Stores polygon vertices, then gives the minimum ray distance to the
// polygon edges for each of N equally spaced angles around the origin.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid_i/in_ready_o, vertex_x/y, last  | vertex requests
//  out     | out_valid_o/out_ready_i, index, distance | one per sample bin
//  cfg     | cfg_we_i, cfg_wdata_i                    | num_samples write
//
// Vertex load: one vertex request per cycle while in_ready_o is high.
// Polygon: a CORDIC vectoring for the first vertex and for each further
// edge's end vertex (none for the closing edge), then per edge/bin pair a
// serial ray-angle divide, a CORDIC rotation and a serial distance divide,
// the last skipped when the denominator is zero; then each bin is read out.
// Input is held off from the last vertex until the final bin is taken.
// Reset clears all valid bits of the distance store at once; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_radial_distance_sampler #(
  parameter int unsigned MAX_SAMPLES  = 64,
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  input  logic        last_vertex_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  sample_index_o,
  output logic [15:0] distance_o,
  output logic        last_sample_o,
  output logic        vertices_dropped_o
);
  import prds_pkg::*;

  localparam int unsigned SIW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);

  localparam logic [4:0] ST_LOAD  = 5'd0;
  localparam logic [4:0] ST_RD0   = 5'd1;
  localparam logic [4:0] ST_V0    = 5'd2;
  localparam logic [4:0] ST_V0W   = 5'd3;
  localparam logic [4:0] ST_NEXTQ = 5'd4;
  localparam logic [4:0] ST_QD    = 5'd5;
  localparam logic [4:0] ST_QW    = 5'd6;
  localparam logic [4:0] ST_KR1   = 5'd7;
  localparam logic [4:0] ST_KR2   = 5'd8;
  localparam logic [4:0] ST_KR3   = 5'd9;
  localparam logic [4:0] ST_BIN   = 5'd10;
  localparam logic [4:0] ST_PDIV  = 5'd11;
  localparam logic [4:0] ST_ROT   = 5'd12;
  localparam logic [4:0] ST_DSUB  = 5'd13;
  localparam logic [4:0] ST_DDIV  = 5'd14;
  localparam logic [4:0] ST_ORD   = 5'd15;
  localparam logic [4:0] ST_OLAT  = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  logic [4:0]       state_q, state_d;
  logic [NS_W-1:0]  num_samples_q, ns_q, ns_clamp;
  logic [VCW-1:0]   vcnt_q;
  logic             ovf_q;
  logic [VAW-1:0]   v_q;
  logic [SIW-1:0]   jj_q, stop_q, oj_q, jj_nx;
  logic [MAX_SAMPLES-1:0] dvalid_q;

  // memories
  logic [31:0]       vmem [MAX_VERTICES];
  logic [31:0]       vrd_q;
  logic [VAW-1:0]    vraddr;
  logic [DIST_W-1:0] dmem [MAX_SAMPLES];
  logic [DIST_W-1:0] drd_q, dcur;
  logic              dval_rd_q;
  logic [SIW-1:0]    draddr;

  // datapath registers
  logic signed [15:0] px_q, py_q, qx_q, qy_q, v0x_q, v0y_q, cvx_q, cvy_q;
  logic [TW-1:0]      tp_q, tq_q, t0_q, tfin;
  logic signed [31:0] prod1_q, prod2_q;
  logic signed [32:0] kr_q;
  logic [8:0]         sraw_q, eraw_q;
  logic [32:0]        num_q;
  logic signed [16:0] ex_q, ey_q;
  logic signed [48:0] m1_q, m2_q;
  logic [DIST_W-1:0]  cur_q, out_dist_q;

  logic in_acc, out_acc, last_edge, bin_done, write_ok, d_zero;
  logic [NS_W-1:0] jj7;

  // CORDIC and divider
  cordic_req_t          creq;
  logic signed [XW-1:0] cx0, cy0, cx, cy;
  logic signed [ZW-1:0] cz0, cz;
  logic                 cdone;
  logic                 dstart, ddone;
  logic [DIV_WN-1:0]    dnum, dquo;
  logic [DIV_WD-1:0]    dden;

  logic signed [16:0] vx17, vy17, ax17, ay17;
  logic [30:0]        ph31;
  logic signed [31:0] ang;
  logic signed [49:0] dval;
  logic [49:0]        dabs;
  logic signed [ZW:0] traw;
  logic [39:0]        sprod, eprod;
  logic [40:0]        sround;
  logic [8:0]         s_sel, e_sel, s_mod, e1;
  logic [8:0]         ns9;
  logic [SIW-1:0]     stop_nx;

  assign in_acc    = (state_q == ST_LOAD) && in_valid_i;
  assign out_acc   = (state_q == ST_OUT) && out_ready_i;
  assign last_edge = (VCW'(v_q) + VCW'(1)) == vcnt_q;
  assign bin_done  = jj_q == stop_q;
  assign jj7       = NS_W'(jj_q) + NS_W'(1);
  assign jj_nx     = (jj7 == ns_q) ? '0 : jj7[SIW-1:0];
  assign ns9       = {2'b00, ns_q};

  always_comb begin
    if (num_samples_q == '0) begin
      ns_clamp = NS_W'(1);
    end else if (num_samples_q > NS_W'(MAX_SAMPLES)) begin
      ns_clamp = NS_W'(MAX_SAMPLES);
    end else begin
      ns_clamp = num_samples_q;
    end
  end

  // vertex angle setup for vectoring
  always_comb begin
    vx17 = {vrd_q[31], vrd_q[31:16]};
    vy17 = {vrd_q[15], vrd_q[15:0]};
    ax17 = vx17[16] ? -vx17 : vx17;
    ay17 = vx17[16] ? -vy17 : vy17;
  end

  // ray angle, reduced to a half turn
  always_comb begin
    ph31 = dquo[30:0] + 31'h4000_0000;
    ang  = $signed({1'b0, ph31}) - 32'sd1073741824;
  end

  always_comb begin
    creq.start = 1'b0;
    creq.mode  = CM_VECTOR;
    cx0 = {{(XW-33){ax17[16]}}, ax17, 16'b0};
    cy0 = {{(XW-33){ay17[16]}}, ay17, 16'b0};
    cz0 = '0;
    unique case (state_q)
      ST_V0, ST_QD: creq.start = 1'b1;
      ST_PDIV: begin
        creq.start = ddone;
        creq.mode  = CM_ROTATE;
        cx0 = INV_GAIN;
        cy0 = '0;
        cz0 = {{(ZW-32){ang[31]}}, ang};
      end
      default: ;
    endcase
  end

  // final vertex angle
  always_comb begin
    traw = '0;
    tfin = '0;
    if (cvy_q == 16'sd0) begin
      tfin = cvx_q[15] ? TURN : HALF_TURN;
    end else if (cvx_q == 16'sd0) begin
      tfin = cvy_q[15] ? QUARTER_TURN : THREE_QUARTER;
    end else begin
      if (cvx_q[15]) begin
        traw = $signed({cz[ZW-1], cz}) +
               $signed({2'b00, (cvy_q > 16'sd0) ? TURN : TW'(0)});
      end else begin
        traw = $signed({cz[ZW-1], cz}) + $signed({2'b00, HALF_TURN});
      end
      if (traw[ZW]) begin
        tfin = '0;
      end else if (traw > $signed({2'b00, TURN})) begin
        tfin = TURN;
      end else begin
        tfin = traw[TW-1:0];
      end
    end
  end

  // bin range of an edge
  always_comb begin
    sprod  = tp_q * ns_q;
    eprod  = tq_q * ns_q;
    sround = {1'b0, sprod} + 41'h0_FFFF_FFFF;
    s_sel  = kr_q[32] ? eraw_q : sraw_q;
    e_sel  = kr_q[32] ? sraw_q : eraw_q;
    s_mod  = (s_sel == ns9) ? 9'd0 : s_sel;
    e1     = e_sel + 9'd1;
    if (ns_q == NS_W'(1)) begin
      stop_nx = '0;
    end else if (e1 >= ns9) begin
      stop_nx = SIW'(e1 - ns9);
    end else begin
      stop_nx = SIW'(e1);
    end
  end

  always_comb begin
    dval   = $signed({m1_q[48], m1_q}) - $signed({m2_q[48], m2_q});
    dabs   = dval[49] ? 50'(-dval) : 50'(dval);
    d_zero = dval == '0;
    dcur   = dval_rd_q ? drd_q : DIST_INIT;
    write_ok = dquo < DIV_WN'(cur_q);
  end

  always_comb begin
    dstart = 1'b0;
    dnum   = DIV_WN'(jj_q) << 32;
    dden   = DIV_WD'(ns_q);
    unique case (state_q)
      ST_BIN:  dstart = !bin_done;
      ST_DSUB: begin
        dstart = !d_zero;
        dnum   = DIV_WN'(num_q) << 30;
        dden   = DIV_WD'(dabs);
      end
      default: ;
    endcase
  end

  prds_cordic #(
    .Steps (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .x0_i   (cx0),
    .y0_i   (cy0),
    .z0_i   (cz0),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz),
    .done_o (cdone)
  );

  prds_div #(
    .Wn (DIV_WN),
    .Wd (DIV_WD)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .num_i   (dnum),
    .den_i   (dden),
    .quo_o   (dquo),
    .done_o  (ddone)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_acc && last_vertex_i) state_d = ST_RD0;
      ST_RD0:   state_d = ST_V0;
      ST_V0:    state_d = ST_V0W;
      ST_V0W:   if (cdone) state_d = ST_NEXTQ;
      ST_NEXTQ: state_d = last_edge ? ST_KR1 : ST_QD;
      ST_QD:    state_d = ST_QW;
      ST_QW:    if (cdone) state_d = ST_KR1;
      ST_KR1:   state_d = ST_KR2;
      ST_KR2:   state_d = ST_KR3;
      ST_KR3:   state_d = ST_BIN;
      ST_BIN: begin
        if (!bin_done) begin
          state_d = ST_PDIV;
        end else if (last_edge) begin
          state_d = ST_ORD;
        end else begin
          state_d = ST_NEXTQ;
        end
      end
      ST_PDIV:  if (ddone) state_d = ST_ROT;
      ST_ROT:   if (cdone) state_d = ST_DSUB;
      ST_DSUB:  state_d = d_zero ? ST_BIN : ST_DDIV;
      ST_DDIV:  if (ddone) state_d = ST_BIN;
      ST_ORD:   state_d = ST_OLAT;
      ST_OLAT:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) state_d = last_sample_o ? ST_LOAD : ST_ORD;
      end
      default:  state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      num_samples_q <= NS_W'(64);
      ns_q          <= NS_W'(1);
      vcnt_q        <= '0;
      ovf_q         <= 1'b0;
      v_q           <= '0;
      jj_q          <= '0;
      stop_q        <= '0;
      oj_q          <= '0;
      dvalid_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        num_samples_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        if (vcnt_q < VCW'(MAX_VERTICES)) begin
          vcnt_q <= vcnt_q + VCW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
        if (last_vertex_i) begin
          ns_q <= ns_clamp;
        end
      end
      unique case (state_q)
        ST_V0W: v_q <= '0;
        ST_KR3: begin
          jj_q   <= SIW'(s_mod);
          stop_q <= stop_nx;
        end
        ST_BIN: begin
          if (bin_done) begin
            v_q  <= v_q + VAW'(1);
            oj_q <= '0;
          end
        end
        ST_DSUB: if (d_zero) jj_q <= jj_nx;
        ST_DDIV: begin
          if (ddone) begin
            jj_q <= jj_nx;
            if (write_ok) dvalid_q[jj_q] <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            oj_q <= oj_q + SIW'(1);
            if (last_sample_o) begin
              vcnt_q   <= '0;
              ovf_q    <= 1'b0;
              dvalid_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // vertex store
  assign vraddr = (state_q == ST_NEXTQ) ? VAW'(v_q + VAW'(1)) : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc && (vcnt_q < VCW'(MAX_VERTICES))) begin
      vmem[vcnt_q[VAW-1:0]] <= {vertex_x_i, vertex_y_i};
    end
    vrd_q <= vmem[vraddr];
  end

  // distance store, read-modify-write one bin at a time
  assign draddr = (state_q == ST_ORD) ? oj_q : jj_q;

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DDIV) && ddone && write_ok) begin
      dmem[jj_q] <= dquo[DIST_W-1:0];
    end
    drd_q     <= dmem[draddr];
    dval_rd_q <= dvalid_q[draddr];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_V0: begin
        px_q  <= vrd_q[31:16];
        py_q  <= vrd_q[15:0];
        v0x_q <= vrd_q[31:16];
        v0y_q <= vrd_q[15:0];
        cvx_q <= vrd_q[31:16];
        cvy_q <= vrd_q[15:0];
      end
      ST_V0W: begin
        if (cdone) begin
          tp_q <= tfin;
          t0_q <= tfin;
        end
      end
      ST_NEXTQ: begin
        if (last_edge) begin
          qx_q <= v0x_q;
          qy_q <= v0y_q;
          tq_q <= t0_q;
        end
      end
      ST_QD: begin
        qx_q  <= vrd_q[31:16];
        qy_q  <= vrd_q[15:0];
        cvx_q <= vrd_q[31:16];
        cvy_q <= vrd_q[15:0];
      end
      ST_QW: if (cdone) tq_q <= tfin;
      ST_KR1: begin
        prod1_q <= px_q * qy_q;
        prod2_q <= py_q * qx_q;
      end
      ST_KR2: begin
        kr_q   <= $signed({prod1_q[31], prod1_q}) - $signed({prod2_q[31], prod2_q});
        sraw_q <= sround[40:32];
        eraw_q <= {1'b0, eprod[39:32]};
      end
      ST_KR3: begin
        num_q <= kr_q[32] ? 33'(-kr_q) : 33'(kr_q);
        ex_q  <= $signed({px_q[15], px_q}) - $signed({qx_q[15], qx_q});
        ey_q  <= $signed({py_q[15], py_q}) - $signed({qy_q[15], qy_q});
      end
      ST_BIN: begin
        if (bin_done && !last_edge) begin
          px_q <= qx_q;
          py_q <= qy_q;
          tp_q <= tq_q;
        end
      end
      ST_ROT: begin
        if (cdone) begin
          m1_q <= $signed(cx[31:0]) * ey_q;
          m2_q <= $signed(cy[31:0]) * ex_q;
        end
      end
      ST_DSUB: cur_q <= dcur;
      ST_OLAT: out_dist_q <= dcur;
      default: ;
    endcase
  end

  assign in_ready_o         = state_q == ST_LOAD;
  assign out_valid_o        = state_q == ST_OUT;
  assign sample_index_o     = 6'(oj_q);
  assign distance_o         = out_dist_q;
  assign last_sample_o      = (NS_W'(oj_q) + NS_W'(1)) == ns_q;
  assign vertices_dropped_o = ovf_q;

endmodule

`default_nettype wire

// ----- rtl/prds_cordic.sv -----
// ----------------------------------------------------------------------------
// prds_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
`default_nettype none

module prds_cordic #(
  parameter int unsigned Steps = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  prds_pkg::cordic_req_t            req_i,
  input  logic signed [prds_pkg::XW-1:0]   x0_i,
  input  logic signed [prds_pkg::XW-1:0]   y0_i,
  input  logic signed [prds_pkg::ZW-1:0]   z0_i,
  output logic signed [prds_pkg::XW-1:0]   x_o,
  output logic signed [prds_pkg::XW-1:0]   y_o,
  output logic signed [prds_pkg::ZW-1:0]   z_o,
  output logic                             done_o
);
  import prds_pkg::*;

  logic                busy_q, done_q;
  logic [STEP_W-1:0]   cnt_q;
  cordic_mode_e        mode_q;
  logic signed [XW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q, at;
  logic                neg;

  always_comb begin
    dx  = x_q >>> cnt_q;
    dy  = y_q >>> cnt_q;
    at  = $signed({{(ZW-30){1'b0}}, ATAN_TURN[cnt_q]});
    neg = (mode_q == CM_VECTOR) ? !y_q[XW-1] : z_q[ZW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(Steps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= x0_i;
      y_q    <= y0_i;
      z_q    <= z0_i;
      mode_q <= req_i.mode;
    end else if (busy_q) begin
      if (neg) begin
        x_q <= x_q + dy;
        y_q <= y_q - dx;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - dy;
        y_q <= y_q + dx;
        z_q <= z_q - at;
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/prds_div.sv -----
// ----------------------------------------------------------------------------
// prds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prds_div #(
  parameter int unsigned Wn = 62,
  parameter int unsigned Wd = 50
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [Wn-1:0] num_i,
  input  logic [Wd-1:0] den_i,
  output logic [Wn-1:0] quo_o,
  output logic          done_o
);
  localparam int unsigned CntW = $clog2(Wn + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [Wn-1:0]   acc_q;
  logic [Wd-1:0]   rem_q, den_q, rem_nx;
  logic [Wd:0]     trial, diff;
  logic            ge;

  always_comb begin
    trial  = {rem_q, acc_q[Wn-1]};
    ge     = trial >= {1'b0, den_q};
    diff   = trial - {1'b0, den_q};
    rem_nx = ge ? diff[Wd-1:0] : trial[Wd-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(Wn - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[Wn-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign quo_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/prds_checker.sv -----
// ----------------------------------------------------------------------------
// prds_checker
// Port-level checks on the radial distance sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polygon_radial_distance_sampler_defines.svh"

module prds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] distance_o,
  input logic        last_sample_o
);
  import prds_pkg::*;

  // no vertex request is taken while results are pending
  `PRDS_ASSERT_NEVER(a_no_overlap, in_ready_o && out_valid_o, "input open during output")
  // minimum never exceeds its start value
  `PRDS_ASSERT(a_dist_range, out_valid_o |-> distance_o <= DIST_INIT, "distance above start")
  // the final bin returns the block to vertex loading
  `PRDS_ASSERT(a_back_to_load, out_valid_o && out_ready_i && last_sample_o |=> in_ready_o, "no load")
  `PRDS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o), "result dropped")

endmodule

bind polygon_radial_distance_sampler prds_checker u_prds_checker (.*);

`default_nettype wire

// ----- verif/tb_polygon_radial_distance_sampler.sv -----
// ----------------------------------------------------------------------------
// tb_polygon_radial_distance_sampler
// Sends polygons as vertex requests and predicts the distance of every sample
// bin with its own copy of the CORDIC angles, bin ranges and divisions.
// Each result is checked field by field, in order. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
  bit [5:0]  idx;
  bit [15:0] distance;
  bit        last;
  bit        drop;
} bin_result_t;

class radial_scoreboard;
  localparam int MAXV = 64;
  localparam int MAXS = 64;
  localparam int STEPS = 16;
  localparam longint TURN_L = 64'h1_0000_0000;

  longint vx[MAXV];
  longint vy[MAXV];
  int vcount;
  bit overflow;
  int num_samples;
  int errors;
  int polygons;
  bin_result_t pending_bins[$];

  function new();
    vcount = 0;
    overflow = 0;
    num_samples = 64;
    errors = 0;
    polygons = 0;
  endfunction

  function longint vertex_turns(longint x, longint y);
    longint ax, ay, z, t, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? TURN_L : TURN_L / 2;
    if (x == 0) return (y > 0) ? 3 * (TURN_L / 4) : TURN_L / 4;
    ax = ((x < 0) ? -x : x) * 65536;
    ay = ((x < 0) ? -y : y) * 65536;
    for (int i = 0; i < STEPS; i++) begin
      dx = ax >>> i;
      dy = ay >>> i;
      if (ay >= 0) begin
        ax += dy; ay -= dx; z += longint'(prds_pkg::ATAN_TURN[i]);
      end else begin
        ax -= dy; ay += dx; z -= longint'(prds_pkg::ATAN_TURN[i]);
      end
    end
    if (x < 0) t = z + ((y > 0) ? TURN_L : 0);
    else t = TURN_L / 2 + z;
    if (t < 0) t = 0;
    if (t > TURN_L) t = TURN_L;
    return t;
  endfunction

  function void note_vertex(longint x, longint y, bit last_v);
    longint ang[MAXV];
    longint rc[MAXS];
    longint rs[MAXS];
    bit [15:0] dmin[MAXS];
    int ns, n, w;
    longint ph, a, cx, cy, z, dx, dy, kr, ex, ey, d;
    longint unsigned num, st, en, stp, jj, tmp, ad, q;
    bin_result_t r;
    if (vcount < MAXV) begin
      vx[vcount] = x; vy[vcount] = y; vcount++;
    end else begin
      overflow = 1;
    end
    if (!last_v) return;
    ns = num_samples;
    if (ns < 1) ns = 1;
    if (ns > MAXS) ns = MAXS;
    n = vcount;
    for (int v = 0; v < n; v++) ang[v] = vertex_turns(vx[v], vy[v]);
    for (int j = 0; j < ns; j++) begin
      dmin[j] = prds_pkg::DIST_INIT;
      ph = longint'((longint'(j) << 32) / ns);
      a = ((ph + TURN_L / 4) & (TURN_L / 2 - 1)) - TURN_L / 4;
      cx = 652032874; cy = 0; z = a;
      for (int i = 0; i < STEPS; i++) begin
        dx = cx >>> i;
        dy = cy >>> i;
        if (z >= 0) begin
          cx -= dy; cy += dx; z -= longint'(prds_pkg::ATAN_TURN[i]);
        end else begin
          cx += dy; cy -= dx; z += longint'(prds_pkg::ATAN_TURN[i]);
        end
      end
      rc[j] = cx; rs[j] = cy;
    end
    for (int v = 0; v < n; v++) begin
      w = (v + 1 == n) ? 0 : v + 1;
      kr = vx[v] * vy[w] - vy[v] * vx[w];
      ex = vx[v] - vx[w];
      ey = vy[v] - vy[w];
      num = (kr < 0) ? -kr : kr;
      st = (longint'(ang[v]) * ns + TURN_L - 1) >> 32;
      en = (longint'(ang[w]) * ns) >> 32;
      if (kr < 0) begin
        tmp = st; st = en; en = tmp;
      end
      st = st % ns;
      stp = (en + 1) % ns;
      for (jj = st; jj != stp; jj = (jj + 1) % ns) begin
        d = rc[jj] * ey - rs[jj] * ex;
        if (d != 0) begin
          ad = (d < 0) ? -d : d;
          q = (num << 30) / ad;
          if (q < dmin[jj]) dmin[jj] = q[15:0];
        end
      end
    end
    for (int j = 0; j < ns; j++) begin
      r.idx = j[5:0];
      r.distance = dmin[j];
      r.last = (j + 1 == ns);
      r.drop = overflow;
      pending_bins.push_back(r);
    end
    vcount = 0;
    overflow = 0;
    polygons++;
  endfunction

  function void check_bin(bit [5:0] idx, bit [15:0] distance, bit last_s, bit drop);
    bin_result_t e;
    if (pending_bins.size() == 0) begin
      $error("unexpected result: sample_index %0d distance %0d", idx, distance);
      errors++;
      return;
    end
    e = pending_bins.pop_front();
    if (idx !== e.idx) begin
      $error("sample_index: expected %0d, actual %0d", e.idx, idx); errors++;
    end
    if (distance !== e.distance) begin
      $error("distance: expected %0d, actual %0d", e.distance, distance); errors++;
    end
    if (last_s !== e.last) begin
      $error("last_sample: expected %0d, actual %0d", e.last, last_s); errors++;
    end
    if (drop !== e.drop) begin
      $error("vertices_dropped: expected %0d, actual %0d", e.drop, drop); errors++;
    end
  endfunction
endclass

module tb_polygon_radial_distance_sampler;
  localparam int STALL_LIMIT = 2000000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [6:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o;
  logic signed [15:0] vertex_x_i, vertex_y_i;
  logic last_vertex_i;
  logic out_valid_o, out_ready_i;
  logic [5:0] sample_index_o;
  logic [15:0] distance_o;
  logic last_sample_o, vertices_dropped_o;

  radial_scoreboard sb;
  bit idle_en;
  int stall_cnt;
  int sink_burst;
  int requests;

  polygon_radial_distance_sampler uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .vertex_x_i(vertex_x_i), .vertex_y_i(vertex_y_i),
    .last_vertex_i(last_vertex_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .sample_index_o(sample_index_o), .distance_o(distance_o),
    .last_sample_o(last_sample_o), .vertices_dropped_o(vertices_dropped_o)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (sink_burst > 0) begin
      sink_burst <= sink_burst - 1;
      out_ready_i <= 0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      sink_burst <= $urandom_range(0, 11);
      out_ready_i <= 0;
    end else begin
      out_ready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_bin(sample_index_o, distance_o, last_sample_o, vertices_dropped_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit l);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    last_vertex_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_vertex(longint'(x), longint'(y), l);
    requests++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_bins.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_samples(logic [6:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.num_samples = int'(v);
  endtask

  task automatic random_polygon();
    int k;
    logic signed [15:0] x, y;
    k = $urandom_range(1, 8);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        x = 16'($urandom); y = 16'($urandom);
      end else begin
        // points in successive quadrants, anticlockwise
        x = 16'($urandom_range(1, 8000)); y = 16'($urandom_range(1, 8000));
        if (((i * 4) / k) == 1 || ((i * 4) / k) == 2) x = -x;
        if (((i * 4) / k) >= 2) y = -y;
      end
      send_vertex(x, y, i == k - 1);
    end
  endtask

  initial begin
    logic [6:0] ns_list[6];
    sb = new();
    idle_en = 1;
    stall_cnt = 0;
    sink_burst = 0;
    requests = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    in_valid_i = 0;
    vertex_x_i = 0;
    vertex_y_i = 0;
    last_vertex_i = 0;
    out_ready_i = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // reset value of the sample count
    send_vertex(16'sd160, 16'sd160, 0);
    send_vertex(-16'sd160, 16'sd160, 0);
    send_vertex(-16'sd160, -16'sd160, 0);
    send_vertex(16'sd160, -16'sd160, 1);
    set_samples(7'd8);
    // axis vertices, origin, anticlockwise
    send_vertex(-16'sd100, 16'sd0, 0);
    send_vertex(16'sd0, 16'sd0, 0);
    send_vertex(16'sd0, 16'sd50, 1);
    send_vertex(16'sd0, -16'sd70, 0);
    send_vertex(16'sd90, 16'sd0, 0);
    send_vertex(16'sd0, 16'sd90, 1);
    send_vertex(16'sd30, 16'sd40, 1);
    set_samples(7'd0);
    send_vertex(16'sd32767, 16'sd32767, 0);
    send_vertex(-16'sd32768, 16'sd32767, 0);
    send_vertex(-16'sd32768, -16'sd32768, 1);
    set_samples(7'd127);
    send_vertex(16'sd32767, -16'sd32768, 0);
    send_vertex(16'sd32767, 16'sd32767, 0);
    send_vertex(-16'sd32768, 16'sd0, 1);
    set_samples(7'd4);
    // overflowing vertex store
    for (int i = 0; i < 66; i++)
      send_vertex(16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 400) - 200),
                  i == 65);

    ns_list = '{7'd1, 7'd64, 7'd65, 7'd12, 7'd3, 7'd16};
    for (int ph = 0; ph < 6; ph++) begin
      set_samples(ns_list[ph]);
      if (ph == 5) idle_en = 0;
      for (int p = 0; p < 14; p++) begin
        random_polygon();
        if ($urandom_range(0, 3) == 0) send_vertex(16'($urandom), 16'($urandom), 0);
      end
      send_vertex(16'($urandom), 16'($urandom), 1);
      if (ph == 2) set_samples(7'($urandom_range(2, 20)));
    end
    drain();
    $display("Covered %0d vertex requests in %0d polygons, sample counts 0 to 127,",
             requests, sb.polygons);
    $display("axis and extreme vertices, store overflow and random idling.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/prds_pkg.sv
rtl/prds_cordic.sv
rtl/prds_div.sv
rtl/polygon_radial_distance_sampler.sv
rtl/prds_checker.sv
verif/tb_polygon_radial_distance_sampler.sv
